@@ hw/rtl/ipa_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipa_pkg
// Shared types for the indexed pool allocator: status codes, link table
// read and write selects, and the command / status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
package ipa_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    // Link table read address source
    typedef enum logic [1:0] {
        RD_FREE_HEAD,
        RD_USED_HEAD,
        RD_LINK
    } rd_sel_t;

    // Link table write operation
    typedef enum logic [2:0] {
        WR_NONE,
        WR_INIT,
        WR_ALLOC,
        WR_PREV,
        WR_PUSH
    } wr_sel_t;

    // Controller to datapath
    typedef struct packed {
        rd_sel_t rd_sel;
        logic    rd_en;
        wr_sel_t wr_sel;
        logic    capture;
        logic    walk_advance;
        logic    used_from_rd;
        logic    load_result;
        status_t result_status;
        logic    result_grant;
    } ipa_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic free_empty;
        logic used_empty;
        logic slot_bad;
        logic slot_is_head;
        logic nxt_null;
        logic nxt_is_victim;
        logic steps_last;
    } ipa_sts_t;

endpackage

@@ hw/rtl/ipa_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipa_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ipa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/ipa_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipa_datapath
// List heads, walk registers, link table and result registers of the
// pool allocator. Acts on commands from the controller.
// ---------------------------------------------------------------------------
module ipa_datapath #(
    parameter int POOL_SIZE = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      slot_index,
    input  ipa_pkg::ipa_cmd_t cmd,
    output ipa_pkg::ipa_sts_t sts,
    output logic [1:0]      status,
    output logic [7:0]      granted_index
);
    import ipa_pkg::*;

    localparam int IDX_W  = $clog2(POOL_SIZE);
    localparam int LINK_W = $clog2(POOL_SIZE + 1);
    // Null link: one past the last slot
    localparam logic [LINK_W-1:0] SLOT_NULL = LINK_W'(POOL_SIZE);

    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] used_head_reg, used_head_next;
    logic [IDX_W-1:0]  prev_reg, prev_next;
    logic [IDX_W-1:0]  victim_reg, victim_next;
    logic [IDX_W-1:0]  steps_reg, steps_next;
    status_t           status_reg, status_next;
    logic [7:0]        grant_reg, grant_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [LINK_W-1:0] ram_rdata;

    ipa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_SIZE)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read address select
    always_comb
    begin
        case (cmd.rd_sel)
            RD_FREE_HEAD: ram_raddr = free_head_reg[IDX_W-1:0];
            RD_USED_HEAD: ram_raddr = used_head_reg[IDX_W-1:0];
            RD_LINK:      ram_raddr = ram_rdata[IDX_W-1:0];
            default:      ram_raddr = '0;
        endcase
    end

    // Write port select
    always_comb
    begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '0;
        case (cmd.wr_sel)
            WR_INIT:
            begin
                ram_waddr = steps_reg;
                ram_wdata = LINK_W'(steps_reg) + LINK_W'(1);
            end
            WR_ALLOC:
            begin
                ram_waddr = free_head_reg[IDX_W-1:0];
                ram_wdata = used_head_reg;
            end
            WR_PREV:
            begin
                ram_waddr = prev_reg;
                ram_wdata = ram_rdata;
            end
            WR_PUSH:
            begin
                ram_waddr = victim_reg;
                ram_wdata = free_head_reg;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // Head, walk and result updates
    always_comb
    begin
        free_head_next = free_head_reg;
        used_head_next = used_head_reg;
        prev_next      = prev_reg;
        victim_next    = victim_reg;
        steps_next     = steps_reg;
        status_next    = status_reg;
        grant_next     = grant_reg;

        if (cmd.wr_sel == WR_ALLOC)
        begin
            free_head_next = ram_rdata;
            used_head_next = free_head_reg;
        end
        if (cmd.wr_sel == WR_PUSH)
        begin
            free_head_next = LINK_W'(victim_reg);
        end
        if (cmd.used_from_rd)
        begin
            used_head_next = ram_rdata;
        end

        if (cmd.capture)
        begin
            victim_next = IDX_W'(slot_index);
            prev_next   = used_head_reg[IDX_W-1:0];
            steps_next  = '0;
        end
        else if (cmd.walk_advance)
        begin
            prev_next  = ram_rdata[IDX_W-1:0];
            steps_next = steps_reg + IDX_W'(1);
        end
        else if (cmd.wr_sel == WR_INIT)
        begin
            steps_next = steps_reg + IDX_W'(1);
        end

        if (cmd.load_result)
        begin
            status_next = cmd.result_status;
            grant_next  = cmd.result_grant ? 8'(free_head_reg) : 8'd0;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            used_head_reg <= SLOT_NULL;
            steps_reg     <= '0;
        end
        else
        begin
            free_head_reg <= free_head_next;
            used_head_reg <= used_head_next;
            steps_reg     <= steps_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prev_reg   <= prev_next;
        victim_reg <= victim_next;
        status_reg <= status_next;
        grant_reg  <= grant_next;
    end

    // Status to controller
    always_comb
    begin
        sts.free_empty    = free_head_reg >= SLOT_NULL;
        sts.used_empty    = used_head_reg >= SLOT_NULL;
        sts.slot_bad      = 32'(slot_index) >= 32'(POOL_SIZE);
        sts.slot_is_head  = LINK_W'(slot_index) == used_head_reg;
        sts.nxt_null      = ram_rdata >= SLOT_NULL;
        sts.nxt_is_victim = ram_rdata == LINK_W'(victim_reg);
        sts.steps_last    = steps_reg == IDX_W'(POOL_SIZE - 1);
    end

    assign status        = status_reg;
    assign granted_index = grant_reg;

endmodule

@@ hw/rtl/ipa_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipa_ctrl
// Sequencer of the pool allocator: link table init sweep, allocate,
// and free with a walk of the allocated list.
// ---------------------------------------------------------------------------
module ipa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              func,
    input  ipa_pkg::ipa_sts_t sts,
    output ipa_pkg::ipa_cmd_t cmd,
    output logic              busy,
    output logic              done
);
    import ipa_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC,
        S_FREE_HEAD,
        S_WALK,
        S_UNLINK,
        S_PUSH
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;
    logic   done_reg, done_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;

        case (state_reg)
            S_INIT:
            begin
                cmd.wr_sel = WR_INIT;
                if (sts.steps_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (!func)
                    begin
                        if (sts.free_empty)
                        begin
                            cmd.load_result   = 1'b1;
                            cmd.result_status = ST_EMPTY;
                            done_next         = 1'b1;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_FREE_HEAD;
                            cmd.rd_en  = 1'b1;
                            state_next = S_ALLOC;
                        end
                    end
                    else if (sts.slot_bad || sts.used_empty)
                    begin
                        cmd.load_result   = 1'b1;
                        cmd.result_status = ST_BAD;
                        done_next         = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        cmd.rd_sel  = RD_USED_HEAD;
                        cmd.rd_en   = 1'b1;
                        state_next  = sts.slot_is_head ? S_FREE_HEAD : S_WALK;
                    end
                end
            end
            S_ALLOC:
            begin
                // pop free head, push onto allocated list
                cmd.wr_sel        = WR_ALLOC;
                cmd.load_result   = 1'b1;
                cmd.result_status = ST_OK;
                cmd.result_grant  = 1'b1;
                done_next         = 1'b1;
                state_next        = S_IDLE;
            end
            S_FREE_HEAD:
            begin
                // victim is the allocated head: unlink and push in one step
                cmd.used_from_rd  = 1'b1;
                cmd.wr_sel        = WR_PUSH;
                cmd.load_result   = 1'b1;
                cmd.result_status = ST_OK;
                done_next         = 1'b1;
                state_next        = S_IDLE;
            end
            S_WALK:
            begin
                if (sts.nxt_null)
                begin
                    cmd.load_result   = 1'b1;
                    cmd.result_status = ST_BAD;
                    done_next         = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (sts.nxt_is_victim)
                begin
                    // fetch the victim's successor
                    cmd.rd_sel = RD_LINK;
                    cmd.rd_en  = 1'b1;
                    state_next = S_UNLINK;
                end
                else if (sts.steps_last)
                begin
                    cmd.load_result   = 1'b1;
                    cmd.result_status = ST_BAD;
                    done_next         = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    cmd.walk_advance = 1'b1;
                    cmd.rd_sel       = RD_LINK;
                    cmd.rd_en        = 1'b1;
                end
            end
            S_UNLINK:
            begin
                cmd.wr_sel = WR_PREV;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.wr_sel        = WR_PUSH;
                cmd.load_result   = 1'b1;
                cmd.result_status = ST_OK;
                done_next         = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        busy_next = state_next != S_IDLE;
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

@@ hw/rtl/indexed_pool_allocator.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// indexed_pool_allocator
// Free-list pool allocator over POOL_SIZE slots sharing one link table.
//
// A transaction is accepted on a rising edge with start high and busy low;
// func selects allocate (0) or free (1) of slot_index. Each transaction
// returns one result: done is high for one cycle with status and
// granted_index valid. There is no backpressure on the result side.
// From accept to done: errors (pool empty, bad slot, nothing allocated)
// are answered from idle; allocate and free of the allocated head pass
// through S_ALLOC or S_FREE_HEAD; free of a slot further back walks the
// list in S_WALK, then goes through S_UNLINK and S_PUSH; free of a slot
// not on the list ends in the walk with status bad.
// The free walk reads one link per cycle through the link RAM read port,
// so free throughput is set by the slot's depth in the allocated list.
// After reset, busy stays high while the link table is swept to its
// initial chain (slot i links to i+1).
// ---------------------------------------------------------------------------
module indexed_pool_allocator #(
    parameter int POOL_SIZE = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       func,
    input  logic [7:0] slot_index,
    output logic       busy,
    output logic       done,
    output logic [1:0] status,
    output logic [7:0] granted_index
);
    import ipa_pkg::*;

    ipa_cmd_t cmd;
    ipa_sts_t sts;

    ipa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ipa_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .slot_index    (slot_index),
        .cmd           (cmd),
        .sts           (sts),
        .status        (status),
        .granted_index (granted_index)
    );

endmodule

@@ hw/rtl/ipa_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipa_checker
// Port-level checks of the pool allocator, bound to the top level.
// ---------------------------------------------------------------------------
module ipa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input logic [7:0] granted_index
);
    import ipa_pkg::*;

    // An accepted transaction either finishes next cycle or keeps busy high
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted transaction neither done nor busy");

    // No result without an accepted transaction or work in flight
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !done)
        else $error("result without a transaction");

    // Status is a defined code whenever done is high
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_EMPTY || status == ST_BAD))
        else $error("undefined status code");

    // Failed transactions grant nothing
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (granted_index == 8'd0))
        else $error("nonzero grant on failed transaction");

endmodule

bind indexed_pool_allocator ipa_checker u_ipa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .granted_index (granted_index)
);
